### rtl/binary_delta_patch_applier_macros.svh
// Assertion macros used by the checker file of the patch applier.
// Depends on nothing; each macro takes a label, clock, reset and expressions.
`ifndef BINARY_DELTA_PATCH_APPLIER_MACROS_SVH
`define BINARY_DELTA_PATCH_APPLIER_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define BDPA_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bdpa assertion failed");

// Next-cycle implication, disabled while reset is held.
`define BDPA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bdpa assertion failed");

`endif

### rtl/bdpa_pkg.sv
// Package of the binary delta patch applier: word types, phase codes, constants.
// Used by the top level and by its checker; depends on nothing.
`default_nettype none

package bdpa_pkg;

    // Control block: three 8-byte sign-magnitude numbers
    localparam int CONTROL_BYTES = 24;
    localparam int NUM_BYTES     = 8;
    localparam int MAG_W         = 63;
    localparam int CNT_W         = $clog2(CONTROL_BYTES);
    localparam logic [7:0] MAG_MASK  = 8'h7F;
    localparam logic [7:0] SIGN_MASK = 8'h80;

    // Phase codes, one-hot
    typedef enum logic [3:0] {
        PH_GATHER = 4'b0001,
        PH_DIFF   = 4'b0010,
        PH_EXTRA  = 4'b0100,
        PH_ERROR  = 4'b1000
    } phase_t;

    // Input word: one patch byte and the next origin byte
    typedef struct packed {
        logic [7:0] patch_byte;
        logic [7:0] old_byte;
    } in_word_t;

    // Output word: one result per accepted input word
    typedef struct packed {
        logic               byte_valid;
        logic [7:0]         out_byte;
        logic               old_used;
        logic               skip_valid;
        logic signed [63:0] skip_amount;
        logic               error;
    } out_word_t;

endpackage

`default_nettype wire

### rtl/binary_delta_patch_applier.sv
// Top level of the binary delta patch applier: control decode, diff/extra copy.
// Depends on bdpa_pkg for word types, phase codes and control block sizes.
//
//   channel   direction   handshake              word
//   in        input       in_valid / in_ready    in_data  (patch byte, origin byte)
//   out       output      out_valid / out_ready  out_data (byte, skip, error)
//
// One word is taken per cycle while in_ready is high; its result reaches the
// output register in the next cycle, with the phase update and the 63-bit
// length count. in_ready is high whenever the output register is empty or
// being emptied, so a stalled out channel stops input only after one word.
// Reset returns to control gathering; the error phase is left only by reset.
`default_nettype none

module binary_delta_patch_applier (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire bdpa_pkg::in_word_t in_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output bdpa_pkg::out_word_t     out_data
);
    import bdpa_pkg::*;

    localparam logic [CNT_W-1:0] LAST_STORED = CNT_W'(CONTROL_BYTES - 1);

    phase_t             phase_reg, phase_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [7:0]         control_bytes_reg [CONTROL_BYTES-1];
    logic [MAG_W-1:0]   remaining_reg, remaining_next;
    logic [MAG_W-1:0]   extra_reg, extra_next;
    logic [63:0]        skip_reg, skip_next;
    logic               out_valid_reg;
    out_word_t          out_data_reg;

    logic               accept;
    logic               store_byte;
    logic [8*CONTROL_BYTES-1:0] ctrl_vec;
    logic [63:0]        diff_word, extra_word, skip_word;
    logic               diff_neg, extra_neg;
    logic [63:0]        skip_decoded;
    logic               rem_last;
    logic [MAG_W-1:0]   rem_dec;
    out_word_t          result;

    assign accept    = in_valid && in_ready;
    assign in_ready  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Assemble the full control block: stored bytes plus the incoming one
    always_comb
    begin
        for (int i = 0; i < CONTROL_BYTES - 1; i++)
        begin
            ctrl_vec[8*i +: 8] = control_bytes_reg[i];
        end
        ctrl_vec[8*(CONTROL_BYTES-1) +: 8] = in_data.patch_byte;
    end

    // Decode the three sign-magnitude numbers
    assign diff_word  = ctrl_vec[0 +: 8*NUM_BYTES];
    assign extra_word = ctrl_vec[8*NUM_BYTES +: 8*NUM_BYTES];
    assign skip_word  = ctrl_vec[16*NUM_BYTES +: 8*NUM_BYTES];
    assign diff_neg   = diff_word[63] && (diff_word[MAG_W-1:0] != '0);
    assign extra_neg  = extra_word[63] && (extra_word[MAG_W-1:0] != '0);
    assign skip_decoded = skip_word[63] ? (64'd0 - {1'b0, skip_word[MAG_W-1:0]})
                                        : {1'b0, skip_word[MAG_W-1:0]};

    // Count down the current run; the last byte leaves zero
    assign rem_last = (remaining_reg[MAG_W-1:1] == '0);
    assign rem_dec  = rem_last ? '0 : remaining_reg - MAG_W'(1);

    // Work out the result word and the next state
    always_comb
    begin
        phase_next     = phase_reg;
        count_next     = count_reg;
        remaining_next = remaining_reg;
        extra_next     = extra_reg;
        skip_next      = skip_reg;
        store_byte     = 1'b0;
        result         = '0;
        case (phase_reg)
            PH_GATHER:
            begin
                if (count_reg < LAST_STORED)
                begin
                    store_byte = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                end
                else if (diff_neg || extra_neg)
                begin
                    phase_next   = PH_ERROR;
                    result.error = 1'b1;
                end
                else
                begin
                    count_next = '0;
                    skip_next  = skip_decoded;
                    extra_next = extra_word[MAG_W-1:0];
                    if (diff_word[MAG_W-1:0] != '0)
                    begin
                        phase_next     = PH_DIFF;
                        remaining_next = diff_word[MAG_W-1:0];
                    end
                    else if (extra_word[MAG_W-1:0] != '0)
                    begin
                        phase_next     = PH_EXTRA;
                        remaining_next = extra_word[MAG_W-1:0];
                    end
                    else
                    begin
                        remaining_next     = '0;
                        result.skip_valid  = 1'b1;
                        result.skip_amount = skip_decoded;
                    end
                end
            end
            PH_DIFF:
            begin
                result.byte_valid = 1'b1;
                result.out_byte   = in_data.patch_byte + in_data.old_byte;
                result.old_used   = 1'b1;
                remaining_next    = rem_dec;
                if (rem_last)
                begin
                    if (extra_reg != '0)
                    begin
                        phase_next     = PH_EXTRA;
                        remaining_next = extra_reg;
                    end
                    else
                    begin
                        phase_next         = PH_GATHER;
                        count_next         = '0;
                        result.skip_valid  = 1'b1;
                        result.skip_amount = skip_reg;
                    end
                end
            end
            PH_EXTRA:
            begin
                result.byte_valid = 1'b1;
                result.out_byte   = in_data.patch_byte;
                remaining_next    = rem_dec;
                if (rem_last)
                begin
                    phase_next         = PH_GATHER;
                    count_next         = '0;
                    result.skip_valid  = 1'b1;
                    result.skip_amount = skip_reg;
                end
            end
            default:
            begin
                phase_next   = PH_ERROR;
                result.error = 1'b1;
            end
        endcase
    end

    // Advance control state on each accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_GATHER;
            count_reg     <= '0;
            remaining_reg <= '0;
            extra_reg     <= '0;
            skip_reg      <= '0;
        end
        else if (accept)
        begin
            phase_reg     <= phase_next;
            count_reg     <= count_next;
            remaining_reg <= remaining_next;
            extra_reg     <= extra_next;
            skip_reg      <= skip_next;
        end
    end

    // Store gathered control bytes
    always_ff @(posedge clk)
    begin
        if (accept && store_byte)
        begin
            control_bytes_reg[count_reg] <= in_data.patch_byte;
        end
    end

    // Hold the result word until the out channel takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= result;
        end
    end

endmodule

`default_nettype wire

### rtl/bdpa_checker.sv
// Port-level checker for the binary delta patch applier, bound to the top level.
// Depends on bdpa_pkg and on binary_delta_patch_applier_macros.svh.
`default_nettype none

`include "binary_delta_patch_applier_macros.svh"

module bdpa_checker (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                in_valid,
    input wire logic                in_ready,
    input wire bdpa_pkg::in_word_t  in_data,
    input wire logic                out_valid,
    input wire logic                out_ready,
    input wire bdpa_pkg::out_word_t out_data
);
    import bdpa_pkg::*;

    logic in_accept;
    logic err_word_clean;

    assign in_accept = in_valid && in_ready;
    assign err_word_clean = !out_data.byte_valid && !out_data.old_used &&
                            !out_data.skip_valid && (out_data.out_byte == 8'd0) &&
                            (out_data.skip_amount == 64'sd0) && (in_data == in_data);

    // Input stalls only behind a full, unread output register
    `BDPA_ASSERT_IMPLY(a_stall_only_when_full, clk, rst_n, !in_ready, out_valid && !out_ready)

    // Every accepted word yields a result word in the next cycle
    `BDPA_ASSERT_NEXT(a_accept_gives_result, clk, rst_n, in_accept, out_valid)

    // An error word carries no byte and no skip
    `BDPA_ASSERT_IMPLY(a_error_word_clean, clk, rst_n, out_valid && out_data.error, err_word_clean)

    // A stalled result word holds
    `BDPA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))

endmodule

bind binary_delta_patch_applier bdpa_checker u_bdpa_checker (.*);

`default_nettype wire

### tb/tb.sv
`timescale 1ns / 1ps
// Testbench of binary_delta_patch_applier: a scoreboard class predicts each result
// word from the accepted patch words; tasks drive in_valid, a process out_ready.
// Depends on bdpa_pkg for the word types, phase codes and the control block size.

module tb;
    import bdpa_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_OFF_LEN   = 300;
    localparam int PHASE_ITEMS    = 180;

    // Predict the applier and check its result words in order
    class patch_scoreboard;
        phase_t      cur_phase;
        int unsigned ctrl_count;
        logic [7:0]  ctrl_bytes [CONTROL_BYTES-1];
        logic [62:0] remaining;
        logic [62:0] extra_len;
        logic [63:0] skip_val;
        out_word_t   pending_out[$];
        int unsigned mismatches;
        int unsigned checked;
        int unsigned diff_bytes;
        int unsigned extra_bytes;
        int unsigned skips;
        int unsigned error_words;

        function new();
            cur_phase  = PH_GATHER;
            ctrl_count = 0;
            remaining  = '0;
            extra_len  = '0;
            skip_val   = '0;
            mismatches = 0;
            checked    = 0;
            diff_bytes = 0;
            extra_bytes = 0;
            skips      = 0;
            error_words = 0;
        endfunction

        // Signal the skip and go back to gathering
        function void close_triple(inout out_word_t r);
            r.skip_valid  = 1'b1;
            r.skip_amount = skip_val;
            cur_phase     = PH_GATHER;
            ctrl_count    = 0;
            remaining     = '0;
        endfunction

        // Work out the result of one accepted input word
        function void note_patch_word(in_word_t w);
            out_word_t   r;
            logic [191:0] blk;
            logic [63:0] diff_num;
            logic [63:0] extra_num;
            logic [63:0] skip_num;
            r = '0;
            case (cur_phase)
                PH_GATHER:
                begin
                    if (ctrl_count < CONTROL_BYTES - 1)
                    begin
                        ctrl_bytes[ctrl_count] = w.patch_byte;
                        ctrl_count++;
                    end
                    else
                    begin
                        for (int i = 0; i < CONTROL_BYTES - 1; i++)
                            blk[8*i +: 8] = ctrl_bytes[i];
                        blk[191:184] = w.patch_byte;
                        diff_num  = blk[63:0];
                        extra_num = blk[127:64];
                        skip_num  = blk[191:128];
                        // Negative zero counts as zero, any other sign bit is an error
                        if ((diff_num[63] && diff_num[62:0] != '0) ||
                            (extra_num[63] && extra_num[62:0] != '0))
                        begin
                            cur_phase = PH_ERROR;
                            r.error   = 1'b1;
                        end
                        else
                        begin
                            skip_val = skip_num[63] ? (64'd0 - {1'b0, skip_num[62:0]})
                                                    : {1'b0, skip_num[62:0]};
                            extra_len  = extra_num[62:0];
                            remaining  = diff_num[62:0];
                            ctrl_count = 0;
                            if (remaining != '0)
                            begin
                                cur_phase = PH_DIFF;
                            end
                            else if (extra_len != '0)
                            begin
                                cur_phase = PH_EXTRA;
                                remaining = extra_len;
                            end
                            else
                            begin
                                close_triple(r);
                            end
                        end
                    end
                end
                PH_DIFF:
                begin
                    r.byte_valid = 1'b1;
                    r.out_byte   = w.patch_byte + w.old_byte;
                    r.old_used   = 1'b1;
                    if (remaining != '0)
                        remaining = remaining - 1'b1;
                    if (remaining == '0)
                    begin
                        if (extra_len != '0)
                        begin
                            cur_phase = PH_EXTRA;
                            remaining = extra_len;
                        end
                        else
                        begin
                            close_triple(r);
                        end
                    end
                end
                PH_EXTRA:
                begin
                    r.byte_valid = 1'b1;
                    r.out_byte   = w.patch_byte;
                    if (remaining != '0)
                        remaining = remaining - 1'b1;
                    if (remaining == '0)
                        close_triple(r);
                end
                default:
                begin
                    cur_phase = PH_ERROR;
                    r.error   = 1'b1;
                end
            endcase
            pending_out.push_back(r);
        endfunction

        // Compare one result word with the oldest prediction
        function void check_out_word(out_word_t got);
            out_word_t exp;
            if (pending_out.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word: bv=%b byte=%h used=%b sv=%b skip=%h err=%b",
                             got.byte_valid, got.out_byte, got.old_used, got.skip_valid,
                             got.skip_amount, got.error);
                return;
            end
            exp = pending_out.pop_front();
            checked++;
            if (exp.old_used)
                diff_bytes++;
            else if (exp.byte_valid)
                extra_bytes++;
            if (exp.skip_valid)
                skips++;
            if (exp.error)
                error_words++;
            if (got.byte_valid !== exp.byte_valid || got.out_byte !== exp.out_byte ||
                got.old_used !== exp.old_used || got.skip_valid !== exp.skip_valid ||
                got.skip_amount !== exp.skip_amount || got.error !== exp.error)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("mismatch on word %0d: exp bv=%b byte=%h used=%b sv=%b",
                             checked, exp.byte_valid, exp.out_byte, exp.old_used,
                             exp.skip_valid);
                    $display("    exp skip=%h err=%b", exp.skip_amount, exp.error);
                    $display("    got bv=%b byte=%h used=%b sv=%b skip=%h err=%b",
                             got.byte_valid, got.out_byte, got.old_used, got.skip_valid,
                             got.skip_amount, got.error);
                end
            end
        endfunction
    endclass

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    in_word_t  in_data   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_word_t out_data;

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned words_sent    = 0;
    int unsigned hold_requests = 0;
    int unsigned stall_cycles  = 0;

    patch_scoreboard sb = new();

    binary_delta_patch_applier u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Check results first, then note the new input word
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                sb.check_out_word(out_data);
            if (in_valid && in_ready)
                sb.note_patch_word(in_data);
        end
    end

    // Drive out_ready: random idling, or a long hold-off on request
    initial
    begin
        int unsigned hold_left;
        int unsigned holds_seen;
        hold_left  = 0;
        holds_seen = 0;
        forever
        begin
            @(posedge clk);
            if (holds_seen != hold_requests)
            begin
                holds_seen = hold_requests;
                hold_left  = HOLD_OFF_LEN;
            end
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else
            begin
                out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // End the run when no word moves on either channel for too long
    initial
    begin
        while (stall_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
        $display("FAILURE");
        $finish;
    end

    // Offer one word, with random idle cycles ahead of it, and hold until taken
    task automatic send_word(input logic [7:0] patch, input logic [7:0] origin);
        in_word_t w;
        w.patch_byte = patch;
        w.old_byte   = origin;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        words_sent++;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Send the 24 control bytes, little-endian, with junk origin bytes
    task automatic send_control(input logic [63:0] diff_f, input logic [63:0] extra_f,
                                input logic [63:0] skip_f);
        logic [191:0] blk;
        blk = {skip_f, extra_f, diff_f};
        for (int i = 0; i < CONTROL_BYTES; i++)
            send_word(blk[8*i +: 8], 8'($urandom_range(0, 255)));
    endtask

    task automatic send_data(input int n);
        repeat (n)
            send_word(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    endtask

    // Length field; a zero length sometimes carries the sign bit
    function automatic logic [63:0] length_field(input int n);
        logic [63:0] f;
        f = 64'(n);
        if (n == 0 && $urandom_range(0, 3) == 0)
            f[63] = 1'b1;
        return f;
    endfunction

    function automatic logic [63:0] random_skip();
        case ($urandom_range(0, 9))
            0: return {1'b0, {63{1'b1}}};
            1: return {64{1'b1}};
            2: return {1'b1, 63'd0};
            3: return 64'd0;
            default: return {32'($urandom), 32'($urandom)};
        endcase
    endfunction

    // Send well-formed triples with random content until the phase quota is met
    task automatic run_random_phase(input int n_items);
        int unsigned stop_at;
        int d;
        int e;
        stop_at = words_sent + n_items;
        while (words_sent < stop_at)
        begin
            d = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 8);
            e = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 8);
            send_control(length_field(d), length_field(e), random_skip());
            send_data(d + e);
        end
    endtask

    initial
    begin
        int unsigned fails;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: one byte each phase with extreme bytes and the largest skip
        send_control(64'd1, 64'd1, {1'b0, {63{1'b1}}});
        send_word(8'hFF, 8'hFF);
        send_word(8'h00, 8'hFF);
        // Both lengths negative zero: skip on the last control byte, most negative skip
        send_control({1'b1, 63'd0}, {1'b1, 63'd0}, {64{1'b1}});
        // Zero diff length straight to extra, skip of negative zero
        send_control(64'd0, 64'd1, {1'b1, 63'd0});
        send_word(8'h80, 8'h7F);
        // Zero extra length: skip raised with the last diff byte
        send_control(64'd1, 64'd0, 64'd0);
        send_word(8'h7F, 8'h81);

        // Random: sender idles lightly, receiver heavily, then the reverse
        send_idle_pct = 15;
        recv_idle_pct = 65;
        run_random_phase(PHASE_ITEMS);
        send_idle_pct = 65;
        recv_idle_pct = 15;
        run_random_phase(PHASE_ITEMS);

        // No idling, with one long receiver hold-off so the input backs up
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_requests++;
        run_random_phase(PHASE_ITEMS);

        // Negative length last, since the error phase only leaves on reset
        if ($urandom_range(0, 1) == 0)
            send_control({1'b1, 63'($urandom_range(1, 200))}, 64'd3, random_skip());
        else
            send_control(64'd2, {1'b1, 63'($urandom_range(1, 200))}, random_skip());
        send_data(6);
        in_valid <= 1'b0;

        // Drain, then allow for the output register
        @(posedge clk);
        while (sb.pending_out.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        fails = sb.mismatches + sb.pending_out.size();
        $display("Checked %0d result words from %0d patch words: %0d diff bytes,",
                 sb.checked, words_sent, sb.diff_bytes);
        $display("%0d extra bytes, %0d origin skips and %0d error words; %0d mismatches.",
                 sb.extra_bytes, sb.skips, sb.error_words, sb.mismatches);
        if (fails == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
